/* rtl/core/wot_pkg.sv */
// ----------------------------------------------------------------------------
// wot_pkg
// Shared types and constants for the weight-ordered contact table.
// ----------------------------------------------------------------------------
package wot_pkg;

  localparam int unsigned WOT_DEPTH = 16;

  localparam logic [0:0] OP_ADD   = 1'b0;
  localparam logic [0:0] OP_CLEAR = 1'b1;

  // Q16.16 limits
  localparam logic signed [31:0] WGT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WGT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [0:0]         operation;
    logic [31:0]        marker;
    logic signed [31:0] weight_delta;
  } wot_in_t;

  typedef struct packed {
    logic [3:0] final_position;
    logic [4:0] entry_count;
    logic [4:0] high_water;
    logic       dropped;
    logic       saturated;
  } wot_out_t;

  typedef struct packed {
    logic [31:0]        marker;
    logic signed [31:0] weight;
  } wot_entry_t;

endpackage

/* rtl/core/wot_ram.sv */
// ----------------------------------------------------------------------------
// wot_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wot_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/weight_ordered_contact_table.sv */
// ----------------------------------------------------------------------------
// weight_ordered_contact_table
// Contact table kept in descending weight order in one synchronous RAM.
// ----------------------------------------------------------------------------
// Sequence: a clear gives its result at the start edge itself; an add to an
// empty table goes through prep and bubble; a drop on a full table follows a
// search of every entry; an append or a hit searches, then preps and bubbles,
// all on one RAM read port. One transaction at a time; busy stays high until
// the result edge (a clear never raises it). The receiver cannot stall results.
// Reset (rst_n low, synchronous): table empty, high-water zero, RAM not cleared.
// ----------------------------------------------------------------------------
module weight_ordered_contact_table
  import wot_pkg::*;
#(
  parameter int unsigned DEPTH = WOT_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  wot_in_t  in_data,
  output logic     out_valid,
  output wot_out_t out_data
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,   // waiting for a start transaction
    ST_SEARCH, // linear marker search, one entry per cycle
    ST_PREP,   // fetch predecessor of the touched slot
    ST_BUBBLE  // move touched entry toward the front
  } state_t;

  state_t             state_r;
  logic [IDX_W-1:0]   k_r;        // current slot under work
  logic [CNT_W-1:0]   used_r;
  logic [CNT_W-1:0]   peak_r;
  logic [31:0]        mk_r;       // latched transaction marker
  logic signed [31:0] dl_r;       // latched transaction delta
  wot_entry_t         cur_r;      // entry being moved
  logic               sat_r;
  logic               out_valid_r;
  wot_out_t           out_r;

  // RAM ports
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  wot_entry_t       ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  wot_entry_t       ram_rdata;

  // Datapath helpers
  logic               accept;
  logic               match;
  logic               last_entry;
  logic               table_full;
  logic signed [32:0] sum_wide;
  logic               sum_ovf;
  logic signed [31:0] sum_clip;
  logic               move_up;    // touched entry passes its predecessor
  logic [31:0]        k_ext;
  logic [31:0]        used_ext;
  logic [31:0]        peak_ext;
  logic [31:0]        peak_old_ext;
  logic [CNT_W-1:0]   peak_new;

  assign accept     = start && (state_r == ST_IDLE);
  assign match      = (ram_rdata.marker == mk_r);
  assign last_entry = ((CNT_W'(k_r) + CNT_W'(1)) == used_r);
  assign table_full = (used_r == CNT_W'(DEPTH));

  // Saturating Q16.16 accumulate: overflow when the two top bits differ
  assign sum_wide = {ram_rdata.weight[31], ram_rdata.weight} + {dl_r[31], dl_r};
  assign sum_ovf  = sum_wide[32] != sum_wide[31];
  assign sum_clip = sum_ovf ? (sum_wide[32] ? WGT_MIN : WGT_MAX) : sum_wide[31:0];

  // Strictly greater keeps equal weights in arrival order
  assign move_up = (k_r != '0) && (cur_r.weight > ram_rdata.weight);

  assign peak_new = (peak_r < used_r) ? used_r : peak_r;

  // Count fields go out masked to their port widths
  assign k_ext        = 32'(k_r);
  assign used_ext     = 32'(used_r);
  assign peak_ext     = 32'(peak_new);
  assign peak_old_ext = 32'(peak_r);

  always_comb begin
    ram_raddr = '0;
    case (state_r)
      ST_IDLE:   ram_raddr = '0;
      ST_SEARCH: ram_raddr = k_r + IDX_W'(1);
      ST_PREP:   ram_raddr = k_r - IDX_W'(1);
      ST_BUBBLE: ram_raddr = k_r - IDX_W'(2);
      default:   ram_raddr = '0;
    endcase
  end

  // Every bubble cycle writes slot k: either the predecessor shifting down or
  // the touched entry landing in its final slot.
  assign ram_we    = (state_r == ST_BUBBLE);
  assign ram_waddr = k_r;
  assign ram_wdata = move_up ? ram_rdata : cur_r;

  wot_ram #(
    .WIDTH ($bits(wot_entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      k_r         <= '0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            mk_r <= in_data.marker;
            dl_r <= in_data.weight_delta;
            k_r  <= '0;
            if (in_data.operation == OP_CLEAR) begin
              peak_r                  <= peak_new;
              used_r                  <= '0;
              out_valid_r             <= 1'b1;
              out_r.final_position    <= '0;
              out_r.entry_count       <= '0;
              out_r.high_water        <= peak_ext[4:0];
              out_r.dropped           <= 1'b0;
              out_r.saturated         <= 1'b0;
            end else if (used_r == '0) begin
              // empty table: append straight into slot 0
              cur_r.marker <= in_data.marker;
              cur_r.weight <= in_data.weight_delta;
              sat_r        <= 1'b0;
              used_r       <= CNT_W'(1);
              state_r      <= ST_PREP;
            end else begin
              state_r <= ST_SEARCH;
            end
          end
        end

        ST_SEARCH: begin
          if (match) begin
            cur_r.marker <= mk_r;
            cur_r.weight <= sum_clip;
            sat_r        <= sum_ovf;
            state_r      <= ST_PREP;
          end else if (last_entry) begin
            if (table_full) begin
              out_valid_r          <= 1'b1;
              out_r.final_position <= '0;
              out_r.entry_count    <= used_ext[4:0];
              out_r.high_water     <= peak_old_ext[4:0];
              out_r.dropped        <= 1'b1;
              out_r.saturated      <= 1'b0;
              state_r              <= ST_IDLE;
            end else begin
              k_r          <= used_r[IDX_W-1:0];
              cur_r.marker <= mk_r;
              cur_r.weight <= dl_r;
              sat_r        <= 1'b0;
              used_r       <= used_r + CNT_W'(1);
              state_r      <= ST_PREP;
            end
          end else begin
            k_r <= k_r + IDX_W'(1);
          end
        end

        ST_PREP: begin
          state_r <= ST_BUBBLE;
        end

        ST_BUBBLE: begin
          if (move_up) begin
            k_r <= k_r - IDX_W'(1);
          end else begin
            out_valid_r          <= 1'b1;
            out_r.final_position <= k_ext[3:0];
            out_r.entry_count    <= used_ext[4:0];
            out_r.high_water     <= peak_old_ext[4:0];
            out_r.dropped        <= 1'b0;
            out_r.saturated      <= sat_r;
            state_r              <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
